// ----- rtl/samcf_pkg.sv -----
`timescale 1ns / 1ps

package samcf_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
      logic [1:0] command;
      logic [7:0] argument;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       reject;
      logic [7:0] op;
      logic [7:0] param;
   } job_type;

   localparam logic [7:0] FR_START  = 8'h7E;
   localparam logic [7:0] FR_VER    = 8'hFF;
   localparam logic [7:0] FR_LEN    = 8'h06;
   localparam logic [7:0] FR_NOFB   = 8'h00;
   localparam logic [7:0] FR_END    = 8'hEF;
   localparam logic [7:0] OP_PLAY   = 8'h03;
   localparam logic [7:0] OP_VOLUME = 8'h06;
   localparam logic [7:0] OP_LOOP   = 8'h08;
   localparam logic [7:0] OP_STOP   = 8'h16;
   localparam logic [7:0] OP_DONE   = 8'h3D;
   localparam logic [7:0] VOL_MAX   = 8'd30;

   localparam logic [1:0] CMD_PLAY   = 2'd0;
   localparam logic [1:0] CMD_LOOP   = 2'd1;
   localparam logic [1:0] CMD_VOLUME = 2'd2;
   localparam logic [1:0] CMD_STOP   = 2'd3;

   localparam logic [0:0] KIND_BYTE   = 1'b0;
   localparam logic [0:0] KIND_REJECT = 1'b1;

   localparam logic [3:0] POS_HUNT  = 4'd0;
   localparam logic [3:0] POS_CMD   = 4'd3;
   localparam logic [3:0] POS_SUM_E = 4'd6;
   localparam logic [3:0] POS_CK_HI = 4'd7;
   localparam logic [3:0] POS_CK_LO = 4'd8;
   localparam logic [3:0] POS_LAST  = 4'd9;

   // header sum of version and length bytes
   localparam logic [15:0] HDR_SUM = 16'h0105;

endpackage

// ----- rtl/samcf_front.sv -----
`timescale 1ns / 1ps

module samcf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  samcf_pkg::req_type req_data,
   input  logic [7:0]        idle_track,
   input  logic              queue_full,
   output logic              push_valid,
   output samcf_pkg::job_type push_job
);

   logic [3:0]  pos_ff, pos_in;
   logic [10:0] sum_ff, sum_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  ck_hi_ff, ck_hi_in;
   logic [7:0]  ck_lo_ff, ck_lo_in;
   logic        accept;
   logic        frame_ok;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign frame_ok  = (req_data.rx_byte == samcf_pkg::FR_END)
                      && ((16'(sum_ff) + {ck_hi_ff, ck_lo_ff}) == 16'd0)
                      && (cmd_ff == samcf_pkg::OP_DONE);

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      cmd_in     = cmd_ff;
      ck_hi_in   = ck_hi_ff;
      ck_lo_in   = ck_lo_ff;
      push_valid = 1'b0;
      push_job   = '0;
      if (accept) begin
         if (req_data.action) begin
            push_valid = 1'b1;
            case (req_data.command)
               samcf_pkg::CMD_PLAY: begin
                  push_job.reject = (req_data.argument == 8'd0);
                  push_job.op     = samcf_pkg::OP_PLAY;
                  push_job.param  = req_data.argument;
               end
               samcf_pkg::CMD_LOOP: begin
                  push_job.reject = (req_data.argument == 8'd0);
                  push_job.op     = samcf_pkg::OP_LOOP;
                  push_job.param  = req_data.argument;
               end
               samcf_pkg::CMD_VOLUME: begin
                  push_job.op    = samcf_pkg::OP_VOLUME;
                  push_job.param = (req_data.argument > samcf_pkg::VOL_MAX)
                                   ? samcf_pkg::VOL_MAX : req_data.argument;
               end
               default: begin
                  push_job.op    = samcf_pkg::OP_STOP;
                  push_job.param = 8'd0;
               end
            endcase
         end else if (pos_ff == samcf_pkg::POS_HUNT) begin
            if (req_data.rx_byte == samcf_pkg::FR_START) begin
               pos_in = 4'd1;
               sum_in = '0;
            end
         end else if (pos_ff == samcf_pkg::POS_LAST) begin
            pos_in = samcf_pkg::POS_HUNT;
            if (frame_ok) begin
               push_valid      = 1'b1;
               push_job.reject = (idle_track == 8'd0);
               push_job.op     = samcf_pkg::OP_LOOP;
               push_job.param  = idle_track;
            end
         end else begin
            pos_in = pos_ff + 4'd1;
            if (pos_ff <= samcf_pkg::POS_SUM_E) begin
               sum_in = sum_ff + 11'(req_data.rx_byte);
            end
            if (pos_ff == samcf_pkg::POS_CMD) begin
               cmd_in = req_data.rx_byte;
            end
            if (pos_ff == samcf_pkg::POS_CK_HI) begin
               ck_hi_in = req_data.rx_byte;
            end
            if (pos_ff == samcf_pkg::POS_CK_LO) begin
               ck_lo_in = req_data.rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= samcf_pkg::POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
      sum_ff   <= sum_in;
      cmd_ff   <= cmd_in;
      ck_hi_ff <= ck_hi_in;
      ck_lo_ff <= ck_lo_in;
   end

endmodule

// ----- rtl/samcf_queue.sv -----
`timescale 1ns / 1ps

module samcf_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  samcf_pkg::job_type push_job,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop_ready,
   output samcf_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(DEPTH);

   samcf_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (cnt_ff == CNT_TOP);
   assign pop_valid = (cnt_ff != '0);
   assign pop_job   = slot_ff[rd_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_TOP) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_TOP) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/samcf_back.sv -----
`timescale 1ns / 1ps

module samcf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  samcf_pkg::job_type pop_job,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output samcf_pkg::rsp_type rsp_data
);

   samcf_pkg::job_type job_ff, job_in;
   samcf_pkg::rsp_type rsp_ff, rsp_in;
   logic        valid_ff, valid_in;
   logic        active_ff, active_in;
   logic [3:0]  idx_ff, idx_in;
   logic        advance;
   logic [15:0] ck;
   logic [7:0]  beat_byte;

   assign advance   = !valid_ff || !rsp_stall;
   assign pop_ready = advance && !active_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
   assign ck        = 16'd0 - (samcf_pkg::HDR_SUM + 16'(job_ff.op) + 16'(job_ff.param));

   always_comb begin
      case (idx_ff)
         4'd1:    beat_byte = samcf_pkg::FR_VER;
         4'd2:    beat_byte = samcf_pkg::FR_LEN;
         4'd3:    beat_byte = job_ff.op;
         4'd4:    beat_byte = samcf_pkg::FR_NOFB;
         4'd5:    beat_byte = 8'd0;
         4'd6:    beat_byte = job_ff.param;
         4'd7:    beat_byte = ck[15:8];
         4'd8:    beat_byte = ck[7:0];
         4'd9:    beat_byte = samcf_pkg::FR_END;
         default: beat_byte = samcf_pkg::FR_START;
      endcase
   end

   always_comb begin
      job_in    = job_ff;
      rsp_in    = rsp_ff;
      valid_in  = valid_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (advance) begin
         if (active_ff) begin
            valid_in        = 1'b1;
            rsp_in.out_kind = samcf_pkg::KIND_BYTE;
            rsp_in.tx_byte  = beat_byte;
            rsp_in.last     = (idx_ff == samcf_pkg::POS_LAST);
            active_in       = (idx_ff != samcf_pkg::POS_LAST);
            idx_in          = idx_ff + 4'd1;
         end else if (pop_valid) begin
            valid_in = 1'b1;
            job_in   = pop_job;
            if (pop_job.reject) begin
               rsp_in.out_kind = samcf_pkg::KIND_REJECT;
               rsp_in.tx_byte  = 8'd0;
               rsp_in.last     = 1'b1;
            end else begin
               rsp_in.out_kind = samcf_pkg::KIND_BYTE;
               rsp_in.tx_byte  = samcf_pkg::FR_START;
               rsp_in.last     = 1'b0;
               active_in       = 1'b1;
               idx_in          = 4'd1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/serial_audio_module_command_framer_core.sv -----
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// req      in   req_valid/stall    samcf_pkg::req_type
// rsp      out  rsp_valid/stall    samcf_pkg::rsp_type
// csr      in   csr_valid/ready    idle_track, 8 bit
//
// One request beat a cycle while the job queue has room, received bytes and actions alike.
// A frame leaves as ten response beats, a rejection as one; the output stage sets the pace.
// Requests stall only when QUEUE_DEPTH jobs wait behind the one being sent.
// Synchronous reset hunts for a start byte, empties the queue, sets idle_track to 1.

module serial_audio_module_command_framer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  samcf_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output samcf_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   logic [7:0]         idle_track_ff;
   logic               queue_full;
   logic               push_valid;
   samcf_pkg::job_type push_job;
   logic               pop_valid;
   logic               pop_ready;
   samcf_pkg::job_type pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_track_ff <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         idle_track_ff <= csr_data;
      end
   end

   samcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .idle_track (idle_track_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   samcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   samcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
